FILE: hdl/aarm_pkg.sv
`timescale 1ns / 1ps

package aarm_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int OUT_FRAC     = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 30;
    localparam int CS           = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int UW           = FRAC_BITS + 2;
    localparam int MW           = UW + 2;
    localparam int SQRT_BITS    = 31;
    localparam int LAT_NORM     = 2 + SQRT_BITS + UW + 1;
    localparam int LAT_CORDIC   = CS + 2;
    localparam int LAT          = LAT_NORM + 4;
    localparam int OUT_UP       = (OUT_FRAC > FRAC_BITS) ? OUT_FRAC - FRAC_BITS : 0;
    localparam int OUT_DN       = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam logic signed [63:0] ONE_F   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] OUT_ONE = 64'sd1 <<< OUT_FRAC;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    typedef logic signed [UW-1:0] unit_t;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [15:0]        angle;
    } aarm_in_t;

    typedef struct packed {
        logic signed [15:0] r0c0;
        logic signed [15:0] r0c1;
        logic signed [15:0] r0c2;
        logic signed [15:0] r1c0;
        logic signed [15:0] r1c1;
        logic signed [15:0] r1c2;
        logic signed [15:0] r2c0;
        logic signed [15:0] r2c1;
        logic signed [15:0] r2c2;
        logic               zero_axis;
    } aarm_out_t;

    function automatic logic [31:0] atan_at(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] rnd_f(input logic signed [63:0] p);
        return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (FRAC_BITS >= OUT_FRAC)
            r = (v + ((64'sd1 <<< OUT_DN) >>> 1)) >>> OUT_DN;
        else
            r = v <<< OUT_UP;
        if (r > OUT_ONE)
            r = OUT_ONE;
        else if (r < -OUT_ONE)
            r = -OUT_ONE;
        return 16'(r);
    endfunction

endpackage

FILE: hdl/aarm_in_if.sv
`timescale 1ns / 1ps

interface aarm_in_if import aarm_pkg::*; ();
    logic     valid;
    logic     ready;
    aarm_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/aarm_out_if.sv
`timescale 1ns / 1ps

interface aarm_out_if import aarm_pkg::*; ();
    logic      valid;
    logic      ready;
    aarm_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/aarm_norm.sv
`timescale 1ns / 1ps

module aarm_norm import aarm_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] az,
    output unit_t              ux,
    output unit_t              uy,
    output unit_t              uz,
    output logic               zero
);

    localparam int NB = SQRT_BITS;

    logic signed [15:0] a_in [3];
    logic [15:0] mag1_reg [3];
    logic        neg1_reg [3];
    logic [31:0] sq1_reg [3];
    logic [31:0] len2;

    logic [63:0] sq_rem_reg  [0:NB];
    logic [31:0] sq_root_reg [0:NB];
    logic [15:0] sq_mag_reg  [0:NB][3];
    logic        sq_neg_reg  [0:NB][3];
    logic        sq_zero_reg [0:NB];

    logic [63:0]   dv_rem  [0:UW][3];
    logic [UW-1:0] dv_q    [0:UW][3];
    logic          dv_neg  [0:UW][3];
    logic [31:0]   dv_den  [0:UW];
    logic          dv_zero [0:UW];

    logic [63:0]   dv_rem_reg  [1:UW][3];
    logic [UW-1:0] dv_q_reg    [1:UW][3];
    logic          dv_neg_reg  [1:UW][3];
    logic [31:0]   dv_den_reg  [1:UW];
    logic          dv_zero_reg [1:UW];

    unit_t u_reg [3];
    logic  zero_reg;

    assign a_in[0] = ax;
    assign a_in[1] = ay;
    assign a_in[2] = az;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mag1_reg[c] <= a_in[c][15] ? 16'(-a_in[c]) : 16'(a_in[c]);
                neg1_reg[c] <= a_in[c][15];
                sq1_reg[c]  <= 32'(a_in[c] * a_in[c]);
            end
        end
    end

    assign len2 = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0]  <= 64'(len2) << 30;
            sq_root_reg[0] <= '0;
            sq_zero_reg[0] <= (len2 == '0);
            sq_mag_reg[0]  <= mag1_reg;
            sq_neg_reg[0]  <= neg1_reg;
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_sqrt
        localparam int B = NB - 1 - k;
        logic [63:0] cand;

        assign cand = (64'(sq_root_reg[k]) << (B + 1)) | (64'd1 << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_rem_reg[k] >= cand)
                begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k] - cand;
                    sq_root_reg[k+1] <= sq_root_reg[k] | (32'd1 << B);
                end
                else
                begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k];
                    sq_root_reg[k+1] <= sq_root_reg[k];
                end
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_mag_reg[k+1]  <= sq_mag_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
            end
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_div_in
        assign dv_rem[0][c] = 64'(sq_mag_reg[NB][c]) << (FRAC_BITS + 15);
        assign dv_q[0][c]   = '0;
        assign dv_neg[0][c] = sq_neg_reg[NB][c];
    end
    assign dv_den[0]  = sq_root_reg[NB];
    assign dv_zero[0] = sq_zero_reg[NB];

    for (genvar j = 1; j <= UW; j++)
    begin : g_div_map
        assign dv_rem[j]  = dv_rem_reg[j];
        assign dv_q[j]    = dv_q_reg[j];
        assign dv_neg[j]  = dv_neg_reg[j];
        assign dv_den[j]  = dv_den_reg[j];
        assign dv_zero[j] = dv_zero_reg[j];
    end

    for (genvar j = 0; j < UW; j++)
    begin : g_div
        localparam int B = UW - 1 - j;
        logic [63:0] cand;

        assign cand = 64'(dv_den[j]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (dv_rem[j][c] >= cand)
                    begin
                        dv_rem_reg[j+1][c] <= dv_rem[j][c] - cand;
                        dv_q_reg[j+1][c]   <= dv_q[j][c] | (UW'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][c] <= dv_rem[j][c];
                        dv_q_reg[j+1][c]   <= dv_q[j][c];
                    end
                end
                dv_neg_reg[j+1]  <= dv_neg[j];
                dv_den_reg[j+1]  <= dv_den[j];
                dv_zero_reg[j+1] <= dv_zero[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (dv_q[UW][c] > UW'(ONE_F))
                    u_reg[c] <= dv_neg[UW][c] ? -UW'(ONE_F) : UW'(ONE_F);
                else
                    u_reg[c] <= dv_neg[UW][c] ? -$signed(dv_q[UW][c]) : $signed(dv_q[UW][c]);
            end
            zero_reg <= dv_zero[UW];
        end
    end

    assign ux   = u_reg[0];
    assign uy   = u_reg[1];
    assign uz   = u_reg[2];
    assign zero = zero_reg;

endmodule

FILE: hdl/aarm_cordic.sv
`timescale 1ns / 1ps

module aarm_cordic import aarm_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] angle,
    output unit_t       cos_v,
    output unit_t       sin_v
);

    localparam int XW = 34;
    localparam int ZW = 33;
    localparam int RS = 30 - FRAC_BITS;
    localparam logic signed [XW-1:0] HALF = XW'((64'sd1 <<< RS) >>> 1);

    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z_reg [0:CS];
    logic signed [XW-1:0] x_reg [0:CS];
    logic signed [XW-1:0] y_reg [0:CS];
    logic                 neg_reg [0:CS];
    logic signed [XW-1:0] xn;
    logic signed [XW-1:0] yn;
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    unit_t c_reg;
    unit_t s_reg;

    assign z_in = ZW'($signed({angle, 16'd0}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= XW'(CORDIC_GAIN);
            y_reg[0] <= '0;
            if (z_in > (ZW'(1) <<< 30))
            begin
                z_reg[0]   <= z_in - (ZW'(1) <<< 31);
                neg_reg[0] <= 1'b1;
            end
            else if (z_in < -(ZW'(1) <<< 30))
            begin
                z_reg[0]   <= z_in + (ZW'(1) <<< 31);
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]   <= z_in;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CS; i++)
    begin : g_step
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = ZW'(atan_at(i));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign xn = neg_reg[CS] ? -x_reg[CS] : x_reg[CS];
    assign yn = neg_reg[CS] ? -y_reg[CS] : y_reg[CS];
    assign xr = (xn + HALF) >>> RS;
    assign yr = (yn + HALF) >>> RS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (xr > XW'(ONE_F))
                c_reg <= UW'(ONE_F);
            else if (xr < -XW'(ONE_F))
                c_reg <= -UW'(ONE_F);
            else
                c_reg <= UW'(xr);
            if (yr > XW'(ONE_F))
                s_reg <= UW'(ONE_F);
            else if (yr < -XW'(ONE_F))
                s_reg <= -UW'(ONE_F);
            else
                s_reg <= UW'(yr);
        end
    end

    assign cos_v = c_reg;
    assign sin_v = s_reg;

endmodule

FILE: hdl/axis_angle_rotation_matrix_unit.sv
`timescale 1ns / 1ps

// Builds the 3x3 rotation matrix for a rotation axis and a binary angle.
// The item channel carries the three axis components and the angle; the
// result channel carries the nine Q1.14 entries and a flag for a zero axis,
// in which case the identity matrix is returned.
// The result is held in an output register. One item can be transferred in
// every cycle while the receiver does not hold the result channel; the
// depth is set by the bit-serial square root (31 stages) and the restoring
// divider (16 stages) that normalize the axis; the CORDIC runs beside them.
// The whole pipeline advances together: when the receiver holds the result
// channel with a result waiting, every stage holds and the item channel
// is not ready, so nothing is lost or repeated.
// Reset clears all valid bits; the payload registers keep their contents.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    aarm_in_if.sink     item,
    aarm_out_if.source  result
);

    localparam int DLY = LAT_NORM - LAT_CORDIC;
    localparam int PW  = 2 * UW;
    localparam int QW  = UW + 1 + MW;

    logic en;
    logic [LAT-1:0] vld_reg;

    unit_t ux;
    unit_t uy;
    unit_t uz;
    unit_t cv;
    unit_t sv;
    logic  zero_n;
    unit_t dc_reg [0:DLY-1];
    unit_t ds_reg [0:DLY-1];

    logic signed [PW-1:0] pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg;
    logic signed [PW-1:0] pxs_reg, pys_reg, pzs_reg;
    logic signed [UW:0]   t1_reg;
    logic                 z1_reg;

    logic signed [MW-1:0] mxx_reg, myy_reg, mzz_reg, mxy_reg, mxz_reg, myz_reg;
    logic signed [MW-1:0] mxs_reg, mys_reg, mzs_reg;
    logic signed [UW:0]   t2_reg;
    logic                 z2_reg;

    logic signed [QW-1:0] qxx_reg, qyy_reg, qzz_reg, qxy_reg, qxz_reg, qyz_reg;
    logic signed [MW-1:0] sxs_reg, sys_reg, szs_reg;
    logic                 z3_reg;

    logic signed [63:0] txx, tyy, tzz, txy, txz, tyz, xs, ys, zs;
    aarm_out_t res_next;
    aarm_out_t res_reg;

    assign en          = !result.valid || result.ready;
    assign item.ready  = en;
    assign result.valid = vld_reg[LAT-1];
    assign result.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], item.valid};
    end

    aarm_norm u_norm (
        .clk  (clk),
        .en   (en),
        .ax   (item.data.axis_x),
        .ay   (item.data.axis_y),
        .az   (item.data.axis_z),
        .ux   (ux),
        .uy   (uy),
        .uz   (uz),
        .zero (zero_n)
    );

    aarm_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .angle (item.data.angle),
        .cos_v (cv),
        .sin_v (sv)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_reg[0] <= cv;
            ds_reg[0] <= sv;
            for (int i = 1; i < DLY; i++)
            begin
                dc_reg[i] <= dc_reg[i-1];
                ds_reg[i] <= ds_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg <= PW'(ux * ux);
            pyy_reg <= PW'(uy * uy);
            pzz_reg <= PW'(uz * uz);
            pxy_reg <= PW'(ux * uy);
            pxz_reg <= PW'(ux * uz);
            pyz_reg <= PW'(uy * uz);
            pxs_reg <= PW'(ux * ds_reg[DLY-1]);
            pys_reg <= PW'(uy * ds_reg[DLY-1]);
            pzs_reg <= PW'(uz * ds_reg[DLY-1]);
            t1_reg  <= (UW+1)'(ONE_F) - (UW+1)'(dc_reg[DLY-1]);
            z1_reg  <= zero_n;

            mxx_reg <= MW'(rnd_f(64'(pxx_reg)) - ONE_F);
            myy_reg <= MW'(rnd_f(64'(pyy_reg)) - ONE_F);
            mzz_reg <= MW'(rnd_f(64'(pzz_reg)) - ONE_F);
            mxy_reg <= MW'(rnd_f(64'(pxy_reg)));
            mxz_reg <= MW'(rnd_f(64'(pxz_reg)));
            myz_reg <= MW'(rnd_f(64'(pyz_reg)));
            mxs_reg <= MW'(rnd_f(64'(pxs_reg)));
            mys_reg <= MW'(rnd_f(64'(pys_reg)));
            mzs_reg <= MW'(rnd_f(64'(pzs_reg)));
            t2_reg  <= t1_reg;
            z2_reg  <= z1_reg;

            qxx_reg <= QW'(t2_reg * mxx_reg);
            qyy_reg <= QW'(t2_reg * myy_reg);
            qzz_reg <= QW'(t2_reg * mzz_reg);
            qxy_reg <= QW'(t2_reg * mxy_reg);
            qxz_reg <= QW'(t2_reg * mxz_reg);
            qyz_reg <= QW'(t2_reg * myz_reg);
            sxs_reg <= mxs_reg;
            sys_reg <= mys_reg;
            szs_reg <= mzs_reg;
            z3_reg  <= z2_reg;

            res_reg <= res_next;
        end
    end

    assign txx = rnd_f(64'(qxx_reg));
    assign tyy = rnd_f(64'(qyy_reg));
    assign tzz = rnd_f(64'(qzz_reg));
    assign txy = rnd_f(64'(qxy_reg));
    assign txz = rnd_f(64'(qxz_reg));
    assign tyz = rnd_f(64'(qyz_reg));
    assign xs  = 64'(sxs_reg);
    assign ys  = 64'(sys_reg);
    assign zs  = 64'(szs_reg);

    always_comb
    begin
        if (z3_reg)
        begin
            res_next           = '0;
            res_next.r0c0      = to_out(ONE_F);
            res_next.r1c1      = to_out(ONE_F);
            res_next.r2c2      = to_out(ONE_F);
            res_next.zero_axis = 1'b1;
        end
        else
        begin
            res_next.r0c0      = to_out(ONE_F + txx);
            res_next.r0c1      = to_out(txy - zs);
            res_next.r0c2      = to_out(ys + txz);
            res_next.r1c0      = to_out(zs + txy);
            res_next.r1c1      = to_out(ONE_F + tyy);
            res_next.r1c2      = to_out(tyz - xs);
            res_next.r2c0      = to_out(txz - ys);
            res_next.r2c1      = to_out(xs + tyz);
            res_next.r2c2      = to_out(ONE_F + tzz);
            res_next.zero_axis = 1'b0;
        end
    end

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.zero_axis) |->
        (result.data.r0c0 == 16'sd16384 && result.data.r1c1 == 16'sd16384 &&
         result.data.r2c2 == 16'sd16384 && result.data.r0c1 == 16'sd0 &&
         result.data.r1c2 == 16'sd0 && result.data.r2c0 == 16'sd0))
        else $error("zero axis without identity matrix");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.r1c1 <= 16'sd16384 &&
                          result.data.r1c1 >= -16'sd16384))
        else $error("matrix entry out of range");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aarm_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;

    aarm_in_if  item_ch ();
    aarm_out_if result_ch ();

    axis_angle_rotation_matrix_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    aarm_in_t  pending_items[$];
    aarm_out_t expected_matrices[$];
    bit        item_taken;
    bit        hold_result;
    int        send_gap;
    int        recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return rnd_shift(a * b, FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] q14(longint v);
        longint r;
        if (FRAC_BITS >= OUT_FRAC)
            r = rnd_shift(v, FRAC_BITS - OUT_FRAC);
        else
            r = v <<< (OUT_FRAC - FRAC_BITS);
        r = sat(r, 64'sd1 <<< OUT_FRAC);
        return 16'(r);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint unit_part(longint a, longint len);
        longint unsigned m;
        longint unsigned q;
        m = (a < 0) ? -a : a;
        q = (m << (FRAC_BITS + 15)) / len;
        if (q > (64'd1 << FRAC_BITS))
            q = 64'd1 << FRAC_BITS;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic aarm_out_t rotation_matrix(aarm_in_t it);
        aarm_out_t m;
        longint ax, ay, az, one, len, x, y, z, c, s, t, cx, cy, cz;
        longint ang, steps;
        bit flip;
        longint e[9];
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        one = 64'sd1 <<< FRAC_BITS;
        m = '0;
        if (ax == 0 && ay == 0 && az == 0)
        begin
            m.r0c0 = q14(one);
            m.r1c1 = q14(one);
            m.r2c2 = q14(one);
            m.zero_axis = 1'b1;
            return m;
        end
        len = int_sqrt(longint'(ax * ax + ay * ay + az * az) << 30);
        x = unit_part(ax, len);
        y = unit_part(ay, len);
        z = unit_part(az, len);
        ang = longint'($signed({it.angle, 16'h0000}));
        flip = 1'b0;
        if (ang > (64'sd1 <<< 30))
        begin
            ang -= 64'sd1 <<< 31;
            flip = 1'b1;
        end
        else if (ang < -(64'sd1 <<< 30))
        begin
            ang += 64'sd1 <<< 31;
            flip = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        steps = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
        for (int i = 0; i < steps; i++)
        begin
            longint dx, dy;
            dx = shr_floor(cy, i);
            dy = shr_floor(cx, i);
            if (ang >= 0)
            begin
                cx -= dx;
                cy += dy;
                ang -= longint'(atan_at(i));
            end
            else
            begin
                cx += dx;
                cy -= dy;
                ang += longint'(atan_at(i));
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        c = sat(rnd_shift(cx, 30 - FRAC_BITS), one);
        s = sat(rnd_shift(cy, 30 - FRAC_BITS), one);
        t = one - c;
        e[0] = one + fmul(t, fmul(x, x) - one);
        e[1] = -fmul(z, s) + fmul(t, fmul(x, y));
        e[2] = fmul(y, s) + fmul(t, fmul(x, z));
        e[3] = fmul(z, s) + fmul(t, fmul(x, y));
        e[4] = one + fmul(t, fmul(y, y) - one);
        e[5] = -fmul(x, s) + fmul(t, fmul(y, z));
        e[6] = -fmul(y, s) + fmul(t, fmul(x, z));
        e[7] = fmul(x, s) + fmul(t, fmul(y, z));
        e[8] = one + fmul(t, fmul(z, z) - one);
        m.r0c0 = q14(e[0]);
        m.r0c1 = q14(e[1]);
        m.r0c2 = q14(e[2]);
        m.r1c0 = q14(e[3]);
        m.r1c1 = q14(e[4]);
        m.r1c2 = q14(e[5]);
        m.r2c0 = q14(e[6]);
        m.r2c1 = q14(e[7]);
        m.r2c2 = q14(e[8]);
        m.zero_axis = 1'b0;
        return m;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7fff;
        if (r == 2)
            return 16'(int'($urandom_range(0, 6)) - 3);
        if (r == 3)
            return 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic add_item(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] a);
        aarm_in_t it;
        it.axis_x = x;
        it.axis_y = y;
        it.axis_z = z;
        it.angle = a;
        pending_items.push_back(it);
    endtask

    // The driver changes the item channel at the falling edge. Whether the
    // offered item was taken is recorded at the rising edge by the monitor
    // below, so the driver acts on the transfer that actually took place.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (!item_ch.valid || item_taken)
            begin
                if (send_gap > 0)
                begin
                    item_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.data <= pending_items.pop_front();
                    send_gap <= pick_gap();
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else if (hold_result)
            result_ch.ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            result_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        item_taken <= rst_n && item_ch.valid && item_ch.ready;
        if (rst_n && item_ch.valid && item_ch.ready)
            expected_matrices.push_back(rotation_matrix(item_ch.data));
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_matrices.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                aarm_out_t exp_m;
                aarm_out_t got;
                exp_m = expected_matrices.pop_front();
                got = result_ch.data;
                if (got.r0c0 !== exp_m.r0c0) begin $error("r0c0 exp %0d got %0d", exp_m.r0c0, got.r0c0); errors++; end
                if (got.r0c1 !== exp_m.r0c1) begin $error("r0c1 exp %0d got %0d", exp_m.r0c1, got.r0c1); errors++; end
                if (got.r0c2 !== exp_m.r0c2) begin $error("r0c2 exp %0d got %0d", exp_m.r0c2, got.r0c2); errors++; end
                if (got.r1c0 !== exp_m.r1c0) begin $error("r1c0 exp %0d got %0d", exp_m.r1c0, got.r1c0); errors++; end
                if (got.r1c1 !== exp_m.r1c1) begin $error("r1c1 exp %0d got %0d", exp_m.r1c1, got.r1c1); errors++; end
                if (got.r1c2 !== exp_m.r1c2) begin $error("r1c2 exp %0d got %0d", exp_m.r1c2, got.r1c2); errors++; end
                if (got.r2c0 !== exp_m.r2c0) begin $error("r2c0 exp %0d got %0d", exp_m.r2c0, got.r2c0); errors++; end
                if (got.r2c1 !== exp_m.r2c1) begin $error("r2c1 exp %0d got %0d", exp_m.r2c1, got.r2c1); errors++; end
                if (got.r2c2 !== exp_m.r2c2) begin $error("r2c2 exp %0d got %0d", exp_m.r2c2, got.r2c2); errors++; end
                if (got.zero_axis !== exp_m.zero_axis)
                begin
                    $error("zero_axis exp %0b got %0b", exp_m.zero_axis, got.zero_axis);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        hold_result = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_item(16'h0000, 16'h0000, 16'h0000, 16'h1234);
        add_item(16'h0000, 16'h0000, 16'h0000, 16'hffff);
        add_item(16'h7fff, 16'h0000, 16'h0000, 16'h4000);
        add_item(16'h8000, 16'h0000, 16'h0000, 16'hc000);
        add_item(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
        add_item(16'h0000, 16'h0000, 16'h8000, 16'h0000);
        add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        add_item(16'h8000, 16'h8000, 16'h8000, 16'h2000);
        add_item(16'h0001, 16'h0000, 16'h0000, 16'h4001);
        add_item(16'hffff, 16'h0001, 16'hffff, 16'h3fff);
        add_item(16'h0001, 16'h0001, 16'h0001, 16'hbfff);
        add_item(16'h8000, 16'h7fff, 16'h0001, 16'hc001);
        add_item(16'h5555, 16'haaaa, 16'h1234, 16'h8001);
        add_item(16'h0000, 16'h0003, 16'h0004, 16'h7fff);
        add_item(16'hfffd, 16'h0000, 16'h0004, 16'h0001);
        add_item(16'h7fff, 16'h8000, 16'h7fff, 16'haaaa);
        add_item(16'h0000, 16'h0000, 16'h0001, 16'h5555);
        wait (pending_items.size() == 0 && !item_ch.valid);
        wait (expected_matrices.size() == 0);

        // The receiver stalls long enough to fill the pipeline and block the input.
        hold_result = 1'b1;
        for (int i = 0; i < 150; i++)
            add_item(rand_comp(), rand_comp(), rand_comp(), 16'($urandom));
        repeat (200) @(posedge clk);
        @(negedge clk);
        hold_result = 1'b0;
        wait (pending_items.size() == 0 && !item_ch.valid);
        wait (expected_matrices.size() == 0);

        for (int i = 0; i < 300; i++)
            add_item(rand_comp(), rand_comp(), rand_comp(), 16'($urandom));
        wait (pending_items.size() == 0 && !item_ch.valid);
        wait (expected_matrices.size() == 0);
        repeat (LAT + 20) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
